[rtl/mda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_pkg
// Shared types and constants for the Minkowski distance accumulator.
// ----------------------------------------------------------------------------
package mda_pkg;

  localparam int DefSampleWidth = 16;
  localparam int DefMaxLength   = 1024;
  localparam int SumW           = 63;
  localparam int DiffW          = 17;

  localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};

  // register indexes
  localparam logic [0:0] REG_POWER_ORDER = 1'b0;
  localparam logic [0:0] REG_TAKE_ROOT   = 1'b1;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [62:0] distance;
    logic        saturated;
  } out_item_t;

  // one finished vector handed from the accumulator to the root unit
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            sat;
    logic [1:0]      order;
    logic            root;
  } vec_item_t;

endpackage

[rtl/minkowski_distance_accumulator.sv]
`timescale 1ns / 1ps
// Path: a last pair passes stages s1, s2, s3 and the output register to the queue;
//   the root unit then forms a square or cube root, one result bit per cycle.
// Throughput: one element pair per cycle unless the queue is full; one vector
//   result per root run, a two-entry queue lets the next vector overlap the root.
// Reset: synchronous active-low; clears the sum, flag, queue and root unit,
//   power_order returns to 2 and take_root to 1.
// ----------------------------------------------------------------------------
// minkowski_distance_accumulator
// Streams pairs; emits the order 1/2/3 Minkowski distance or power sum per vector.
// ----------------------------------------------------------------------------
module minkowski_distance_accumulator import mda_pkg::*; #(
  parameter int SAMPLE_WIDTH = DefSampleWidth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_data
);

  logic [1:0] power_order_r;
  logic       take_root_r;
  vec_item_t  a2q, q2r;
  logic       a2q_v, a2q_r, q2r_v, q2r_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_order_r <= 2'd2;
      take_root_r   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POWER_ORDER: power_order_r <= cfg_data;
        REG_TAKE_ROOT:   take_root_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mda_accum #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_accum (
    .clk, .rst_n, .in_data, .in_valid, .in_ready,
    .power_order(power_order_r), .take_root(take_root_r),
    .q_data(a2q), .q_valid(a2q_v), .q_ready(a2q_r)
  );

  mda_queue u_queue (
    .clk, .rst_n, .wr_data(a2q), .wr_valid(a2q_v), .wr_ready(a2q_r),
    .rd_data(q2r), .rd_valid(q2r_v), .rd_ready(q2r_r)
  );

  mda_root u_root (
    .clk, .rst_n, .q_data(q2r), .q_valid(q2r_v), .q_ready(q2r_r),
    .out_data, .out_valid, .out_ready
  );

  // held result stays stable while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a presented result carries known values
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result has unknown bits");

endmodule

[rtl/mda_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_accum
// Front part: forms |a-b| power terms and accumulates them with saturation.
// ----------------------------------------------------------------------------
module mda_accum import mda_pkg::*; #(
  parameter int SAMPLE_WIDTH = DefSampleWidth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] power_order,
  input  logic      take_root,
  output vec_item_t q_data,
  output logic      q_valid,
  input  logic      q_ready
);

  localparam int SW = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;

  // stage 1: difference magnitude
  logic               s1_v_r;
  logic [DiffW-1:0]   s1_d_r;
  logic [1:0]         s1_ord_r;
  logic               s1_last_r, s1_root_r;
  // stage 2: square
  logic               s2_v_r;
  logic [2*DiffW-1:0] s2_sq_r;
  logic [DiffW-1:0]   s2_d_r;
  logic [1:0]         s2_ord_r;
  logic               s2_last_r, s2_root_r;
  // stage 3: term
  logic               s3_v_r;
  logic [SumW-1:0]    s3_term_r;
  logic [1:0]         s3_ord_r;
  logic               s3_last_r, s3_root_r;

  logic [SumW-1:0] sum_r;
  logic            sat_r;
  logic            out_v_r;
  vec_item_t       out_r;

  logic signed [SW:0] a_ext, b_ext, diff;
  logic [DiffW-1:0]   dmag;
  logic [1:0]         ord;
  logic               adv;
  logic [SumW:0]      sum_add;
  logic [3*DiffW-1:0] cube;

  // whole pipe stalls when the queue entry waits
  assign adv      = !(out_v_r && !q_ready);
  assign in_ready = adv;
  assign q_valid  = out_v_r;
  assign q_data   = out_r;

  assign a_ext = {in_data.elem_a[SW-1], in_data.elem_a[SW-1:0]};
  assign b_ext = {in_data.elem_b[SW-1], in_data.elem_b[SW-1:0]};
  assign diff  = a_ext - b_ext;
  assign dmag  = DiffW'(diff[SW] ? -diff : diff);
  assign ord   = (power_order == 2'd0) ? 2'd1 : power_order;
  assign cube  = s2_sq_r * {{(2*DiffW){1'b0}}, s2_d_r};
  assign sum_add = {1'b0, sum_r} + {1'b0, s3_term_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sum_r   <= '0;
      sat_r   <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= in_valid;
      s1_d_r    <= dmag;
      s1_ord_r  <= ord;
      s1_last_r <= in_data.last;
      s1_root_r <= take_root;

      s2_v_r    <= s1_v_r;
      s2_sq_r   <= s1_d_r * s1_d_r;
      s2_d_r    <= s1_d_r;
      s2_ord_r  <= s1_ord_r;
      s2_last_r <= s1_last_r;
      s2_root_r <= s1_root_r;

      // |d| < 2^17 so square and cube never exceed the sum range
      s3_v_r    <= s2_v_r;
      s3_term_r <= (s2_ord_r == 2'd1) ? SumW'(s2_d_r) :
                   (s2_ord_r == 2'd2) ? SumW'(s2_sq_r) : SumW'(cube);
      s3_ord_r  <= s2_ord_r;
      s3_last_r <= s2_last_r;
      s3_root_r <= s2_root_r;

      out_v_r <= s3_v_r && s3_last_r;
      if (s3_v_r) begin
        // saturating accumulate
        if (sum_add[SumW]) begin
          out_r.sum <= SUM_MAX;
        end else begin
          out_r.sum <= sum_add[SumW-1:0];
        end
        out_r.sat   <= sat_r | sum_add[SumW];
        out_r.order <= s3_ord_r;
        out_r.root  <= s3_root_r;
        if (s3_last_r) begin
          sum_r   <= '0;
          sat_r   <= 1'b0;
        end else begin
          sum_r <= sum_add[SumW] ? SUM_MAX : sum_add[SumW-1:0];
          sat_r <= sat_r | sum_add[SumW];
        end
      end
    end
  end

endmodule

[rtl/mda_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_queue
// Two-entry queue between accumulator and root unit.
// ----------------------------------------------------------------------------
module mda_queue import mda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  vec_item_t wr_data,
  input  logic      wr_valid,
  output logic      wr_ready,
  output vec_item_t rd_data,
  output logic      rd_valid,
  input  logic      rd_ready
);

  vec_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        mem_r[wp_r] <= wr_data;
        wp_r        <= ~wp_r;
      end
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[rtl/mda_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mda_root
// Back part: bit-serial floor square or cube root of the vector sum, or the sum as is.
// ----------------------------------------------------------------------------
module mda_root import mda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  vec_item_t q_data,
  input  logic      q_valid,
  output logic      q_ready,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SQRT, ST_CBRT, ST_DONE} state_t;

  state_t          state_r;
  logic [SumW:0]   x_r;      // remainder, 64 bits
  logic [SumW:0]   y_r;      // partial root / result bit
  logic [SumW:0]   bit_r;
  logic [6:0]      s_r;      // cube shift
  logic [20:0]     cy_r;     // cube root < 2^21
  logic            sat_r;
  out_item_t       res_r;

  logic [SumW:0]   sq_trial;
  logic [20:0]     cy_sh;
  logic [SumW:0]   cb_b;
  logic [SumW:0]   x_shr;
  logic [41:0]     cy_prod;

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_data  = res_r;

  assign sq_trial = y_r + bit_r;
  assign cy_sh    = {cy_r[19:0], 1'b0};
  assign cy_prod  = {21'd0, cy_sh} * {21'd0, cy_sh + 21'd1};
  assign cb_b     = 64'(cy_prod) * 64'd3 + 64'd1;
  assign x_shr    = x_r >> s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            x_r   <= {1'b0, q_data.sum};
            sat_r <= q_data.sat;
            y_r   <= '0;
            bit_r <= 64'h4000_0000_0000_0000;
            s_r   <= 7'd63;
            cy_r  <= '0;
            if (q_data.root && q_data.order == 2'd2) begin
              state_r <= ST_SQRT;
            end else if (q_data.root && q_data.order == 2'd3) begin
              state_r <= ST_CBRT;
            end else begin
              res_r   <= '{distance: q_data.sum, saturated: q_data.sat};
              state_r <= ST_DONE;
            end
          end
        end
        ST_SQRT: begin
          // one result bit per cycle
          if (x_r >= sq_trial) begin
            x_r <= x_r - sq_trial;
            y_r <= (y_r >> 1) + bit_r;
          end else begin
            y_r <= y_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            res_r.distance  <= (x_r >= sq_trial) ? SumW'((y_r >> 1) + bit_r)
                                                 : SumW'(y_r >> 1);
            res_r.saturated <= sat_r;
            state_r <= ST_DONE;
          end
        end
        ST_CBRT: begin
          // one result bit per cycle, 22 steps
          if (x_shr >= cb_b) begin
            x_r  <= x_r - (cb_b << s_r);
            cy_r <= cy_sh + 21'd1;
          end else begin
            cy_r <= cy_sh;
          end
          s_r <= s_r - 7'd3;
          if (s_r == 7'd0) begin
            res_r.distance  <= SumW'((x_shr >= cb_b) ? cy_sh + 21'd1 : cy_sh);
            res_r.saturated <= sat_r;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
